@@ hw/rtl/msd_pkg.sv @@
// Shared types, widths and constants for the mean square displacement engine.
package msd_pkg;

  localparam int POS_W    = 21;
  localparam int POS3_W   = 3 * POS_W;
  localparam int MAG_W    = POS_W;
  localparam int SQ_W     = 2 * MAG_W;
  localparam int SUM3_W   = SQ_W + 2;
  localparam int ACC_W    = 64;
  localparam int MEAN_W   = 44;

  localparam int NF_W     = 7;
  localparam int NA_W     = 9;
  localparam int LAG_W    = 5;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = NA_W;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ATOM_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LAG_COUNT   = 2'd2;

  localparam logic [NF_W-1:0]  FRAME_COUNT_RESET = 7'd64;
  localparam logic [NA_W-1:0]  ATOM_COUNT_RESET  = 9'd256;
  localparam logic [LAG_W-1:0] LAG_COUNT_RESET   = 5'd10;

  localparam int MAX_LAG        = 16;
  localparam int DEF_MAX_FRAMES = 64;
  localparam int DEF_MAX_ATOMS  = 256;

  typedef enum logic [2:0] {
    S_LOAD,
    S_LAG_INIT,
    S_ISSUE,
    S_DRAIN,
    S_DIV_START,
    S_DIV_WAIT,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic lag_init;
    logic issue;
    logic div_start;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic last_load;
    logic none;
    logic q_end;
    logic pipe_busy;
    logic div_busy;
    logic out_free;
    logic last_lag;
  } dp_status_t;

endpackage

@@ hw/rtl/msd_div.sv @@
// Restoring divider, one quotient bit per cycle.
module msd_div #(
  parameter int DVS_W = 15
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [msd_pkg::ACC_W-1:0] dividend,
  input  logic [DVS_W-1:0]          divisor,
  output logic                      busy,
  output logic [msd_pkg::ACC_W-1:0] quotient
);
  import msd_pkg::*;

  localparam int CW = $clog2(ACC_W + 1);

  logic [DVS_W-1:0] rem;
  logic [CW-1:0]    count;
  logic [DVS_W:0]   rem_sh;
  logic [DVS_W:0]   diff;

  assign busy   = (count != '0);
  assign rem_sh = {rem, quotient[ACC_W-1]};
  assign diff   = rem_sh - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (start) begin
      count <= CW'(ACC_W);
    end else if (busy) begin
      count <= count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
    end else if (busy) begin
      if (!diff[DVS_W]) begin
        rem      <= diff[DVS_W-1:0];
        quotient <= {quotient[ACC_W-2:0], 1'b1};
      end else begin
        rem      <= rem_sh[DVS_W-1:0];
        quotient <= {quotient[ACC_W-2:0], 1'b0};
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) start |=> busy)
    else $error("divider did not start");
  assert property (@(posedge clk) disable iff (rst)
    (count == CW'(1)) |=> !busy)
    else $error("divider ran past its last bit");
  assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider restarted while busy");

endmodule

@@ hw/rtl/msd_datapath.sv @@
// Position store, pair walk, squared-distance pipeline, accumulator, divider and result register.
module msd_datapath #(
  parameter int MAX_FRAMES = msd_pkg::DEF_MAX_FRAMES,
  parameter int MAX_ATOMS  = msd_pkg::DEF_MAX_ATOMS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  msd_pkg::ctrl_cmd_t            cmd,
  output msd_pkg::dp_status_t           status,
  input  logic                          restart,
  input  logic [msd_pkg::NF_W-1:0]      nf,
  input  logic [msd_pkg::NA_W-1:0]      na,
  input  logic [msd_pkg::LAG_W-1:0]     nl,
  input  logic [msd_pkg::POS_W-1:0]     pos_x,
  input  logic [msd_pkg::POS_W-1:0]     pos_y,
  input  logic [msd_pkg::POS_W-1:0]     pos_z,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [msd_pkg::LAG_W-1:0]     lag,
  output logic [msd_pkg::MEAN_W-1:0]    mean_sq,
  output logic                          no_pairs,
  output logic                          last
);
  import msd_pkg::*;

  localparam int DEPTH  = MAX_FRAMES * MAX_ATOMS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  logic [POS3_W-1:0] mem [DEPTH];

  logic [ADDR_W-1:0] load_index;
  logic [ADDR_W-1:0] p_addr;
  logic [ADDR_W-1:0] q_addr;
  logic [CNT_W-1:0]  total;
  logic [CNT_W-1:0]  offset;
  logic [CNT_W-1:0]  pairs;
  logic [LAG_W-1:0]  lag_counter;
  logic [ACC_W-1:0]  sum_accumulator;
  logic [ACC_W:0]    acc_sum;

  logic [POS3_W-1:0] rd_p;
  logic [POS3_W-1:0] rd_q;
  logic              v1, v2, v3, v4;
  logic [MAG_W-1:0]  mag      [3];
  logic [MAG_W-1:0]  mag_next [3];
  logic [SQ_W-1:0]   sq       [3];
  logic [SUM3_W-1:0] s3;

  logic              div_busy;
  logic [ACC_W-1:0]  quotient;
  logic [MEAN_W-1:0] mean_sat;

  assign total = CNT_W'(nf) * CNT_W'(na);

  assign status.last_load = (CNT_W'(load_index) + CNT_W'(1)) == total;
  assign status.q_end     = (CNT_W'(q_addr) + CNT_W'(1)) == total;
  assign status.none      = NF_W'(lag_counter) >= nf;
  assign status.last_lag  = lag_counter == nl;
  assign status.pipe_busy = v1 | v2 | v3 | v4;
  assign status.div_busy  = div_busy;
  assign status.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mem[load_index] <= {pos_z, pos_y, pos_x};
    end
    if (cmd.issue) begin
      rd_p <= mem[p_addr];
      rd_q <= mem[q_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_index  <= '0;
      lag_counter <= '0;
      offset      <= '0;
    end else if (restart) begin
      load_index <= '0;
    end else if (cmd.load) begin
      if (status.last_load) begin
        load_index  <= '0;
        lag_counter <= LAG_W'(1);
        offset      <= CNT_W'(na);
      end else begin
        load_index <= load_index + ADDR_W'(1);
      end
    end else if (cmd.emit && !status.last_lag) begin
      lag_counter <= lag_counter + LAG_W'(1);
      offset      <= offset + CNT_W'(na);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lag_init) begin
      p_addr <= '0;
      q_addr <= offset[ADDR_W-1:0];
      pairs  <= total - offset;
    end else if (cmd.issue) begin
      p_addr <= p_addr + ADDR_W'(1);
      q_addr <= q_addr + ADDR_W'(1);
    end
  end

  always_comb begin
    logic signed [POS_W:0] d;
    for (int k = 0; k < 3; k++) begin
      d = $signed({rd_p[k*POS_W + POS_W - 1], rd_p[k*POS_W +: POS_W]})
        - $signed({rd_q[k*POS_W + POS_W - 1], rd_q[k*POS_W +: POS_W]});
      mag_next[k] = d[POS_W] ? MAG_W'(-d) : MAG_W'(d);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= cmd.issue;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      mag[k] <= mag_next[k];
      sq[k]  <= mag[k] * mag[k];
    end
    s3 <= SUM3_W'(sq[0]) + SUM3_W'(sq[1]) + SUM3_W'(sq[2]);
  end

  assign acc_sum = {1'b0, sum_accumulator} + (ACC_W + 1)'(s3);

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_accumulator <= '0;
    end else if (cmd.lag_init) begin
      sum_accumulator <= '0;
    end else if (v4) begin
      sum_accumulator <= acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
    end
  end

  msd_div #(
    .DVS_W(CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (sum_accumulator),
    .divisor  (pairs),
    .busy     (div_busy),
    .quotient (quotient)
  );

  assign mean_sat = (|quotient[ACC_W-1:MEAN_W]) ? '1 : quotient[MEAN_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      lag      <= lag_counter;
      mean_sq  <= status.none ? '0 : mean_sat;
      no_pairs <= status.none;
      last     <= status.last_lag;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    cmd.issue |-> (CNT_W'(q_addr) < total))
    else $error("pair walk ran past the loaded positions");
  assert property (@(posedge clk) disable iff (rst)
    (cmd.lag_init && !status.none) |=> (pairs != '0))
    else $error("lag with pairs has a zero pair count");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && no_pairs) |-> (mean_sq == '0))
    else $error("lag without pairs carries a nonzero mean");

endmodule

@@ hw/rtl/msd_ctrl.sv @@
// Sequencer for loading, the per-lag pair walk, division and result hand-off.
module msd_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  msd_pkg::dp_status_t status,
  output msd_pkg::ctrl_cmd_t  cmd
);
  import msd_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_LOAD: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
        if (in_valid && status.last_load) begin
          state_next = S_LAG_INIT;
        end
      end
      S_LAG_INIT: begin
        cmd.lag_init = 1'b1;
        state_next   = status.none ? S_EMIT : S_ISSUE;
      end
      S_ISSUE: begin
        cmd.issue = 1'b1;
        if (status.q_end) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!status.pipe_busy) begin
          state_next = S_DIV_START;
        end
      end
      S_DIV_START: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (!status.div_busy) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = status.last_lag ? S_LOAD : S_LAG_INIT;
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && status.last_lag) |=> (state == S_LOAD))
    else $error("no return to loading after the final lag");
  assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !status.pipe_busy)
    else $error("division started before the pipeline drained");
  assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> status.out_free)
    else $error("result written over an untaken beat");

endmodule

@@ hw/rtl/mean_square_displacement_engine.sv @@
// Positions are taken one beat per cycle while loading (in_ready high); the beat that
// completes the data set starts the computation and in_ready stays low until the final
// lag's result is in the output register. Each lag with pairs walks (frames - lag) *
// atoms position pairs, one pair per cycle on the two read ports of the position store,
// then drains the pipeline, runs the bit-serial divider and hands the result off; a lag
// with no pairs goes straight to the hand-off. A result waits in the output register
// until taken, and the next lag is worked on meanwhile; its hand-off holds until the
// register is free.
module mean_square_displacement_engine #(
  parameter int MAX_FRAMES = msd_pkg::DEF_MAX_FRAMES,
  parameter int MAX_ATOMS  = msd_pkg::DEF_MAX_ATOMS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [msd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [msd_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [msd_pkg::POS_W-1:0]         pos_x,
  input  logic [msd_pkg::POS_W-1:0]         pos_y,
  input  logic [msd_pkg::POS_W-1:0]         pos_z,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [msd_pkg::LAG_W-1:0]         lag,
  output logic [msd_pkg::MEAN_W-1:0]        mean_sq,
  output logic                              no_pairs,
  output logic                              last
);
  import msd_pkg::*;

  logic [NF_W-1:0]  frame_count;
  logic [NA_W-1:0]  atom_count;
  logic [LAG_W-1:0] lag_count;
  logic [NF_W-1:0]  nf;
  logic [NA_W-1:0]  na;
  logic [LAG_W-1:0] nl;
  logic             restart;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  always_comb begin
    restart = 1'b0;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_COUNT, REG_ATOM_COUNT, REG_LAG_COUNT: restart = 1'b1;
        default:                                        restart = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= FRAME_COUNT_RESET;
      atom_count  <= ATOM_COUNT_RESET;
      lag_count   <= LAG_COUNT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_COUNT: frame_count <= cfg_data[NF_W-1:0];
        REG_ATOM_COUNT:  atom_count  <= cfg_data[NA_W-1:0];
        REG_LAG_COUNT:   lag_count   <= cfg_data[LAG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (frame_count == '0) begin
      nf = NF_W'(1);
    end else if (32'(frame_count) > MAX_FRAMES) begin
      nf = NF_W'(MAX_FRAMES);
    end else begin
      nf = frame_count;
    end
    if (atom_count == '0) begin
      na = NA_W'(1);
    end else if (32'(atom_count) > MAX_ATOMS) begin
      na = NA_W'(MAX_ATOMS);
    end else begin
      na = atom_count;
    end
    if (lag_count == '0) begin
      nl = LAG_W'(1);
    end else if (32'(lag_count) > MAX_LAG) begin
      nl = LAG_W'(MAX_LAG);
    end else begin
      nl = lag_count;
    end
  end

  msd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  msd_datapath #(
    .MAX_FRAMES(MAX_FRAMES),
    .MAX_ATOMS (MAX_ATOMS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .restart   (restart),
    .nf        (nf),
    .na        (na),
    .nl        (nl),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .pos_z     (pos_z),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .lag       (lag),
    .mean_sq   (mean_sq),
    .no_pairs  (no_pairs),
    .last      (last)
  );

endmodule
